[src/u2u_pkg.sv]
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// No dependencies; imported by every module of the block.
package u2u_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned UNIT_W   = 16;
   localparam int unsigned ACCUM_W  = 21;
   localparam int unsigned QUEUE_D  = 4;
   localparam int unsigned QPTR_W   = $clog2(QUEUE_D);
   localparam int unsigned QCNT_W   = $clog2(QUEUE_D + 1);

   localparam logic [ACCUM_W-1:0] MIN_TWO   = 21'h00080;
   localparam logic [ACCUM_W-1:0] MIN_THREE = 21'h00800;
   localparam logic [ACCUM_W-1:0] MIN_FOUR  = 21'h10000;
   localparam logic [ACCUM_W-1:0] MAX_POINT = 21'h10FFFF;
   localparam logic [ACCUM_W-1:0] SURR_LO   = 21'h0D800;
   localparam logic [ACCUM_W-1:0] SURR_HI   = 21'h0DFFF;
   localparam logic [UNIT_W-1:0]  HIGH_BASE = 16'hD800;
   localparam logic [UNIT_W-1:0]  LOW_BASE  = 16'hDC00;

   typedef enum logic [1:0] {
      KIND_UNIT  = 2'd0,
      KIND_END   = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      SEQ_NONE  = 2'd0,
      SEQ_TWO   = 2'd1,
      SEQ_THREE = 2'd2,
      SEQ_FOUR  = 2'd3
   } seq_type;

   typedef struct packed {
      logic [UNIT_W-1:0] code_unit;
      kind_type          kind;
      logic              last_of_run;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type res0;
      result_type res1;
   } dec_out_type;

endpackage

[src/u2u_decode.sv]
// Sequence decoder: holds the open UTF-8 sequence and turns one byte into
// zero, one or two results. Depends on u2u_pkg.
module u2u_decode (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  logic [u2u_pkg::BYTE_W-1:0] in_byte,
   output u2u_pkg::dec_out_type     dec_out
);
   import u2u_pkg::*;

   logic [1:0]         pending_ff, pending_in;
   logic [ACCUM_W-1:0] accum_ff, accum_in;
   seq_type            seq_ff, seq_in;
   logic               discard_ff, discard_in;

   logic [ACCUM_W-1:0] acc_next;
   logic [ACCUM_W-1:0] minimum;
   logic [ACCUM_W-1:0] offset;
   logic               bad_point;

   always_comb begin
      acc_next = {accum_ff[ACCUM_W-7:0], in_byte[5:0]};
      case (seq_ff)
         SEQ_TWO:   minimum = MIN_TWO;
         SEQ_THREE: minimum = MIN_THREE;
         default:   minimum = MIN_FOUR;
      endcase
      bad_point = (acc_next < minimum) || (acc_next > MAX_POINT)
                  || ((acc_next >= SURR_LO) && (acc_next <= SURR_HI));
      offset = acc_next - MIN_FOUR;
   end

   always_comb begin
      pending_in = pending_ff;
      accum_in   = accum_ff;
      seq_in     = seq_ff;
      discard_in = discard_ff;
      dec_out    = '0;
      if (fire) begin
         if (discard_ff) begin
            if (in_byte == '0) begin
               discard_in = 1'b0;
               pending_in = '0;
               accum_in   = '0;
               seq_in     = SEQ_NONE;
            end
         end else if (in_byte == '0) begin
            dec_out.count = 2'd1;
            dec_out.res0  = '{code_unit: '0,
                              kind: (pending_ff != '0) ? KIND_ERROR : KIND_END,
                              last_of_run: 1'b1};
            pending_in = '0;
            accum_in   = '0;
            seq_in     = SEQ_NONE;
         end else if (pending_ff != '0) begin
            if (in_byte[7:6] != 2'b10 || (pending_ff == 2'd1 && bad_point)) begin
               pending_in    = '0;
               accum_in      = '0;
               seq_in        = SEQ_NONE;
               discard_in    = 1'b1;
               dec_out.count = 2'd1;
               dec_out.res0  = '{code_unit: '0, kind: KIND_ERROR, last_of_run: 1'b1};
            end else if (pending_ff != 2'd1) begin
               accum_in   = acc_next;
               pending_in = pending_ff - 2'd1;
            end else begin
               pending_in = '0;
               accum_in   = '0;
               seq_in     = SEQ_NONE;
               if (acc_next[ACCUM_W-1:UNIT_W] == '0) begin
                  dec_out.count = 2'd1;
                  dec_out.res0  = '{code_unit: acc_next[UNIT_W-1:0], kind: KIND_UNIT,
                                    last_of_run: 1'b1};
               end else begin
                  dec_out.count = 2'd2;
                  dec_out.res0  = '{code_unit: HIGH_BASE + {6'd0, offset[19:10]},
                                    kind: KIND_UNIT, last_of_run: 1'b0};
                  dec_out.res1  = '{code_unit: LOW_BASE + {6'd0, offset[9:0]},
                                    kind: KIND_UNIT, last_of_run: 1'b1};
               end
            end
         end else if (in_byte[7] == 1'b0) begin
            dec_out.count = 2'd1;
            dec_out.res0  = '{code_unit: {8'd0, in_byte}, kind: KIND_UNIT,
                              last_of_run: 1'b1};
         end else if (in_byte[7:5] == 3'b110) begin
            accum_in   = {16'd0, in_byte[4:0]};
            pending_in = 2'd1;
            seq_in     = SEQ_TWO;
         end else if (in_byte[7:4] == 4'b1110) begin
            accum_in   = {17'd0, in_byte[3:0]};
            pending_in = 2'd2;
            seq_in     = SEQ_THREE;
         end else if (in_byte[7:3] == 5'b11110) begin
            accum_in   = {18'd0, in_byte[2:0]};
            pending_in = 2'd3;
            seq_in     = SEQ_FOUR;
         end else begin
            discard_in    = 1'b1;
            dec_out.count = 2'd1;
            dec_out.res0  = '{code_unit: '0, kind: KIND_ERROR, last_of_run: 1'b1};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         accum_ff   <= '0;
         seq_ff     <= SEQ_NONE;
         discard_ff <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         accum_ff   <= accum_in;
         seq_ff     <= seq_in;
         discard_ff <= discard_in;
      end
   end

endmodule

[src/u2u_outq.sv]
// Result queue: takes up to two results per cycle from the decoder and
// hands one per transfer to the result channel. Depends on u2u_pkg.
module u2u_outq (
   input  logic                 clock,
   input  logic                 reset,
   input  u2u_pkg::dec_out_type dec_out,
   output logic                 room,
   output logic                 out_valid,
   input  logic                 out_ready,
   output u2u_pkg::result_type  out_res
);
   import u2u_pkg::*;

   result_type        mem [QUEUE_D];
   logic [QPTR_W-1:0] wr_ff, wr_in;
   logic [QPTR_W-1:0] rd_ff, rd_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              pop;

   assign out_valid = count_ff != '0;
   assign out_res   = mem[rd_ff];
   assign pop       = out_valid && out_ready;
   assign room      = count_ff <= QCNT_W'(QUEUE_D - 2);

   always_comb begin
      wr_in    = wr_ff + QPTR_W'(dec_out.count);
      rd_in    = rd_ff + QPTR_W'(pop);
      count_in = count_ff + QCNT_W'(dec_out.count) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (dec_out.count != 2'd0) begin
         mem[wr_ff] <= dec_out.res0;
      end
      if (dec_out.count == 2'd2) begin
         mem[wr_ff + QPTR_W'(1)] <= dec_out.res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

[src/utf8_to_utf16_transcoder.sv]
// Top level of the UTF-8 to UTF-16 transcoder: input register, decoder and
// result queue. Depends on u2u_pkg, u2u_decode and u2u_outq.
//
// Takes one UTF-8 byte per transfer and accepts a byte every cycle while the
// result side keeps up. A byte enters an input register, is decoded once the
// queue has room and its results land in a four-entry queue, so a byte passes
// the input register and the queue before its first result is offered. A
// supplementary code point gives two results (high then low surrogate) and
// these leave on two consecutive transfers; the three silent bytes that
// precede it make up for the extra result, so the sustained rate stays one
// byte per cycle. Each zero byte outside a drop gives an end item, or an error
// item if a sequence is open; after any other error one error item is sent
// and bytes are dropped up to and including the next zero byte, which gives
// no item.
module utf8_to_utf16_transcoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] code_unit
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast    // last_of_run
);
   import u2u_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff, in_byte_in;
   logic              room;
   logic              advance;
   dec_out_type       dec_out;
   result_type        out_res;

   assign advance    = in_valid_ff && room;
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   u2u_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .fire    (advance),
      .in_byte (in_byte_ff),
      .dec_out (dec_out)
   );

   u2u_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .dec_out   (dec_out),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (out_res)
   );

   assign rsp_tdata = out_res.code_unit;
   assign rsp_tuser = out_res.kind;
   assign rsp_tlast = out_res.last_of_run;

endmodule

[src/u2u_checker.sv]
// Port-level checks for the UTF-8 to UTF-16 transcoder and the bind that
// attaches them to the top level. Depends on u2u_pkg.
module u2u_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);
   import u2u_pkg::*;

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == KIND_UNIT || rsp_tuser == KIND_END
                     || rsp_tuser == KIND_ERROR)
      else $error("result kind out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_UNIT |-> rsp_tdata == '0 && rsp_tlast)
      else $error("end or error item carries data or lacks last");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[15:10] == 6'b110110)
      else $error("non-final result is not a high surrogate");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && rsp_tlast && rsp_tdata[15:10] == 6'b110111)
      else $error("high surrogate not followed by low surrogate");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

endmodule

bind utf8_to_utf16_transcoder u2u_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
